// ===== rtl/core/pssm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pssm_pkg
// Shared types and constants of the PSSM window scan.
// ----------------------------------------------------------------------------
package pssm_pkg;

  localparam int NUM_CODES = 20;
  localparam int NUM_TYPES = 3;
  localparam int CODE_W    = 5;
  localparam int POS_W     = 6;
  localparam int TYPE_W    = 2;
  localparam int SCORE_W   = 16;
  localparam int SUM_W     = 22;
  localparam int START_W   = 10;
  localparam int MINLEN_W  = 11;
  localparam int CYS_W     = 2;

  localparam logic [CODE_W-1:0] CYS_CODE = 5'd1;
  localparam logic [CYS_W-1:0]  CYS_NEEDED = 2'd2;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_RESIDUE = 1'b1;

  localparam logic REG_MIN_LEN = 1'b0;

  typedef logic signed [SUM_W-1:0] sum_t;
  typedef sum_t [NUM_TYPES-1:0] sum_vec_t;

  typedef struct packed {
    logic                wr_en;
    logic [POS_W-1:0]    wr_pos;
    logic [CODE_W-1:0]   wr_code;
    logic [TYPE_W-1:0]   wr_type;
    logic [SCORE_W-1:0]  wr_value;
    logic                rd_en;
    logic [CODE_W-1:0]   rd_code;
    logic                shift;
    logic                add;
  } cell_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/core/pssm_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pssm_ram
// Single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pssm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 20
) (
  input  wire logic                                   clk,
  input  wire logic                                   wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                       wr_data,
  input  wire logic                                   rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/pssm_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pssm_cell
// One template position: holds its score column per chain type and adds the
// residue score to the window sum handed on from the previous cell.
// ----------------------------------------------------------------------------
module pssm_cell #(
  parameter int INDEX = 0
) (
  input  wire logic                 clk,
  input  wire pssm_pkg::cell_ctl_t  ctl,
  input  wire pssm_pkg::sum_vec_t   acc_in,
  output pssm_pkg::sum_vec_t        acc
);

  logic [pssm_pkg::SCORE_W-1:0] rd_data [pssm_pkg::NUM_TYPES];
  pssm_pkg::sum_vec_t           acc_next;
  logic                         pos_hit;

  assign pos_hit = ctl.wr_en && (ctl.wr_pos == pssm_pkg::POS_W'(INDEX));

  for (genvar k = 0; k < pssm_pkg::NUM_TYPES; k++) begin : g_type
    pssm_ram #(
      .WIDTH (pssm_pkg::SCORE_W),
      .DEPTH (pssm_pkg::NUM_CODES)
    ) u_ram (
      .clk     (clk),
      .wr_en   (pos_hit && (ctl.wr_type == pssm_pkg::TYPE_W'(k))),
      .wr_addr (ctl.wr_code),
      .wr_data (ctl.wr_value),
      .rd_en   (ctl.rd_en),
      .rd_addr (ctl.rd_code),
      .rd_data (rd_data[k])
    );

    assign acc_next[k] = ctl.add ?
      $signed(acc_in[k]) + $signed({
        {(pssm_pkg::SUM_W - pssm_pkg::SCORE_W){rd_data[k][pssm_pkg::SCORE_W-1]}},
        rd_data[k]}) :
      acc_in[k];
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      acc <= acc_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/pssm_window_best_match_scan.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pssm_window_best_match_scan
// Sliding-window PSSM scan over a residue stream, best window per chain type.
//
// Input words carry either a score-table load (opcode 0) or one residue
// (opcode 1). A load writes one score entry of one cell. Residues stream
// at one word per cycle, while item_ready is high, through a chain of
// TEMPLATE_LENGTH cells; cell j adds the table score of position j to the
// window that started j residues earlier, so a window leaves the last cell
// complete. Windows are compared against the running best in the stage
// after the chain. A result word is registered once the residue marked
// last has passed stages s1 and s2; item_ready stays low from that residue
// until the result word is taken, so a stalled receiver holds the input
// side for that sequence end only. Every other word is taken without a
// stall, so a new residue can enter before earlier ones leave the chain;
// each cell's score RAM has a single registered read.
// Reset clears the sequence state, the running best and min_sequence_length;
// the score table is undefined until loaded. The sequence state also clears
// after each last residue; table and register are kept.
// ----------------------------------------------------------------------------
module pssm_window_best_match_scan #(
  parameter int TEMPLATE_LENGTH     = 16,
  parameter int MAX_SEQUENCE_LENGTH = 1024
) (
  input  wire logic                                clk,
  input  wire logic                                rst,

  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [2:0]                          paddr,
  input  wire logic [31:0]                         pwdata,
  output logic      [31:0]                         prdata,
  output logic                                     pready,

  input  wire logic                                item_valid,
  output logic                                     item_ready,
  input  wire logic                                opcode,
  input  wire logic [pssm_pkg::POS_W-1:0]          template_pos,
  input  wire logic [pssm_pkg::CODE_W-1:0]         residue_code,
  input  wire logic [pssm_pkg::TYPE_W-1:0]         chain_type,
  input  wire logic signed [pssm_pkg::SCORE_W-1:0] score_value,
  input  wire logic                                last,

  output logic                                     result_valid,
  input  wire logic                                result_ready,
  output logic                                     status,
  output logic signed [pssm_pkg::SUM_W-1:0]        best_score_a,
  output logic signed [pssm_pkg::SUM_W-1:0]        best_score_b,
  output logic signed [pssm_pkg::SUM_W-1:0]        best_score_c,
  output logic [pssm_pkg::START_W-1:0]             best_start_a,
  output logic [pssm_pkg::START_W-1:0]             best_start_b,
  output logic [pssm_pkg::START_W-1:0]             best_start_c
);

  localparam int CW = $clog2(MAX_SEQUENCE_LENGTH + 2);
  localparam int XW = (CW + 1 > pssm_pkg::MINLEN_W + 1) ? CW + 1 : pssm_pkg::MINLEN_W + 1;
  localparam logic [XW-1:0] MAX_X = XW'(MAX_SEQUENCE_LENGTH);
  localparam logic [XW-1:0] TPL_X = XW'(TEMPLATE_LENGTH);

  // configuration
  logic [pssm_pkg::MINLEN_W-1:0] min_len;
  logic                          cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_len <= '0;
    end else if (cfg_wr && (paddr[2] == pssm_pkg::REG_MIN_LEN)) begin
      min_len <= pwdata[pssm_pkg::MINLEN_W-1:0];
    end
  end

  always_comb begin
    if (paddr[2] == pssm_pkg::REG_MIN_LEN) begin
      prdata = 32'(min_len);
    end else begin
      prdata = '0;
    end
  end

  // sequence state
  logic [CW-1:0]             count;
  logic [pssm_pkg::CYS_W-1:0] cys;
  logic [CW-1:0]             first_start;
  logic                      bad;

  logic                      accept;
  logic                      is_res;
  logic                      in_range;
  logic                      code_ok;
  logic                      cys_hit;
  logic [pssm_pkg::CYS_W-1:0] cys_next;
  logic [CW-1:0]             first_next;
  logic [CW-1:0]             count_next;
  logic                      bad_next;
  logic [XW-1:0]             p1_x;
  logic [XW-1:0]             first_x;
  logic [XW-1:0]             count_x;
  logic [XW-1:0]             start_x;
  logic                      qual;
  logic                      ok;
  logic                      load_ok;

  // pipeline
  logic                        s1_valid;
  logic                        s1_last;
  logic                        s1_qual;
  logic                        s1_ok;
  logic                        s1_shift;
  logic                        s1_add;
  logic [pssm_pkg::START_W-1:0] s1_start;
  logic                        s2_valid;
  logic                        s2_last;
  logic                        s2_qual;
  logic                        s2_ok;
  logic [pssm_pkg::START_W-1:0] s2_start;

  pssm_pkg::sum_vec_t                 best;
  logic [pssm_pkg::START_W-1:0]       best_st [pssm_pkg::NUM_TYPES];
  pssm_pkg::sum_vec_t                 chain [TEMPLATE_LENGTH + 1];
  pssm_pkg::cell_ctl_t                ctl;

  assign item_ready = !(s1_valid && s1_last) && !(s2_valid && s2_last) && !result_valid;
  assign accept     = item_valid && item_ready;
  assign is_res     = (opcode == pssm_pkg::OP_RESIDUE);

  assign in_range = XW'(count) < MAX_X;
  assign code_ok  = residue_code < pssm_pkg::CODE_W'(pssm_pkg::NUM_CODES);
  assign cys_hit  = in_range && (residue_code == pssm_pkg::CYS_CODE) &&
                    (cys < pssm_pkg::CYS_NEEDED);
  assign p1_x     = XW'(count) + XW'(1);

  always_comb begin
    cys_next   = cys;
    first_next = first_start;
    if (cys_hit) begin
      cys_next = cys + pssm_pkg::CYS_W'(1);
      if (cys_next == pssm_pkg::CYS_NEEDED) begin
        first_next = p1_x[CW-1:0];
      end
    end
    if (in_range) begin
      count_next = p1_x[CW-1:0];
    end else begin
      count_next = CW'(MAX_X + XW'(1));
    end
    bad_next = bad || (in_range && !code_ok);
  end

  assign first_x = XW'(first_next);
  assign count_x = XW'(count_next);
  assign start_x = p1_x - TPL_X;
  assign qual    = in_range && !last && (cys_next == pssm_pkg::CYS_NEEDED) &&
                   (p1_x >= first_x + TPL_X);
  assign ok      = !bad_next && (count_x <= MAX_X) && (count_x >= XW'(min_len)) &&
                   (count_x > TPL_X) && (cys_next == pssm_pkg::CYS_NEEDED) &&
                   (first_x + TPL_X < count_x);
  assign load_ok = ({1'b0, template_pos} < (pssm_pkg::POS_W + 1)'(TEMPLATE_LENGTH)) &&
                   code_ok && (chain_type < pssm_pkg::TYPE_W'(pssm_pkg::NUM_TYPES));

  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      cys         <= '0;
      first_start <= '0;
      bad         <= 1'b0;
    end else if (accept && is_res) begin
      if (last) begin
        count       <= '0;
        cys         <= '0;
        first_start <= '0;
        bad         <= 1'b0;
      end else begin
        count       <= count_next;
        cys         <= cys_next;
        first_start <= first_next;
        bad         <= bad_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= accept && is_res;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_last  <= last;
    s1_qual  <= qual;
    s1_ok    <= ok;
    s1_shift <= in_range;
    s1_add   <= in_range && code_ok;
    s1_start <= start_x[pssm_pkg::START_W-1:0];
    s2_last  <= s1_last;
    s2_qual  <= s1_qual;
    s2_ok    <= s1_ok;
    s2_start <= s1_start;
  end

  // cell chain
  always_comb begin
    ctl.wr_en    = accept && !is_res && load_ok;
    ctl.wr_pos   = template_pos;
    ctl.wr_code  = residue_code;
    ctl.wr_type  = chain_type;
    ctl.wr_value = score_value;
    ctl.rd_en    = accept && is_res;
    ctl.rd_code  = residue_code;
    ctl.shift    = s1_valid && s1_shift;
    ctl.add      = s1_add;
  end

  assign chain[0] = '0;

  for (genvar j = 0; j < TEMPLATE_LENGTH; j++) begin : g_cell
    pssm_cell #(
      .INDEX (j)
    ) u_cell (
      .clk    (clk),
      .ctl    (ctl),
      .acc_in (chain[j]),
      .acc    (chain[j+1])
    );
  end

  // best tracking and result word
  always_ff @(posedge clk) begin
    if (rst) begin
      best <= '0;
      for (int k = 0; k < pssm_pkg::NUM_TYPES; k++) begin
        best_st[k] <= '0;
      end
    end else if (s2_valid && s2_last) begin
      best <= '0;
      for (int k = 0; k < pssm_pkg::NUM_TYPES; k++) begin
        best_st[k] <= '0;
      end
    end else if (s2_valid && s2_qual) begin
      for (int k = 0; k < pssm_pkg::NUM_TYPES; k++) begin
        if ($signed(chain[TEMPLATE_LENGTH][k]) > $signed(best[k])) begin
          best[k]    <= chain[TEMPLATE_LENGTH][k];
          best_st[k] <= s2_start;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s2_valid && s2_last) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid && s2_last) begin
      status <= !s2_ok;
      if (s2_ok) begin
        best_score_a <= best[0];
        best_score_b <= best[1];
        best_score_c <= best[2];
        best_start_a <= best_st[0];
        best_start_b <= best_st[1];
        best_start_c <= best_st[2];
      end else begin
        best_score_a <= '0;
        best_score_b <= '0;
        best_score_c <= '0;
        best_start_a <= '0;
        best_start_b <= '0;
        best_start_c <= '0;
      end
    end
  end

endmodule
`default_nettype wire
